[rtl/esa_pkg.sv]
// Shared widths, register codes and reset values of the encoder speed averager.
`default_nettype none

package esa_pkg;

    // Item field widths
    localparam int POS_W  = 32;
    localparam int EL_W   = 24;
    localparam int SPD_W  = 16;

    // Velocity term and shared divider operand width
    localparam int TERM_W = 48;
    localparam int DIV_W  = 48;

    // Configuration port
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SPEED = 1'b0,
        REG_REVERSE   = 1'b1
    } t_cfg_reg;

    localparam logic [CFG_W-1:0] MAX_SPEED_RST = 48'd65536;

endpackage

`default_nettype wire

[rtl/esa_in_if.sv]
// Input channel of the encoder speed averager: position and elapsed ticks.
`default_nettype none

interface esa_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [esa_pkg::POS_W-1:0]    position;
    logic        [esa_pkg::EL_W-1:0]     elapsed;

    modport source (output valid, output position, output elapsed, input ready);
    modport sink   (input valid, input position, input elapsed, output ready);
endinterface

`default_nettype wire

[rtl/esa_out_if.sv]
// Result channel of the encoder speed averager: two Q4.12 speeds and a clip flag.
`default_nettype none

interface esa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [esa_pkg::SPD_W-1:0]    instant_speed;
    logic signed [esa_pkg::SPD_W-1:0]    averaged_speed;
    logic                                saturated;

    modport source (output valid, output instant_speed, output averaged_speed,
                    output saturated, input ready);
    modport sink   (input valid, input instant_speed, input averaged_speed,
                    input saturated, output ready);
endinterface

`default_nettype wire

[rtl/esa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module esa_ram #(
    parameter  int WIDTH  = 48,
    parameter  int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [ADDR_W-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]    i_wdata,
    input  wire logic                i_re,
    input  wire logic [ADDR_W-1:0]   i_raddr,
    output      logic [WIDTH-1:0]    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/esa_div.sv]
// Shared restoring divider, two quotient bits per cycle, left-aligned dividend.
`default_nettype none

module esa_div #(
    parameter int SH_W  = 56,
    parameter int CNT_W = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [esa_pkg::DIV_W-1:0]   i_divisor,
    input  wire logic [esa_pkg::DIV_W-1:0]   i_rem_init,
    input  wire logic [SH_W-1:0]             i_dividend,
    input  wire logic [CNT_W-1:0]            i_pairs,
    output      logic                        o_done,
    output      logic [SH_W-1:0]             o_quotient
);
    localparam int DW = esa_pkg::DIV_W;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_div;
    logic [DW-1:0]    r_rem;
    logic [SH_W-1:0]  r_sh;
    logic [SH_W-1:0]  r_q;

    logic [DW:0]   t1, t2, d1, d2;
    logic          ge1, ge2;
    logic [DW-1:0] rem1, rem2;

    // Two dependent trial subtractions per cycle
    always_comb begin
        t1   = {r_rem, r_sh[SH_W-1]};
        d1   = t1 - {1'b0, r_div};
        ge1  = (t1 >= {1'b0, r_div});
        rem1 = ge1 ? d1[DW-1:0] : t1[DW-1:0];
        t2   = {rem1, r_sh[SH_W-2]};
        d2   = t2 - {1'b0, r_div};
        ge2  = (t2 >= {1'b0, r_div});
        rem2 = ge2 ? d2[DW-1:0] : t2[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_pairs;
                r_div  <= i_divisor;
                r_rem  <= i_rem_init;
                r_sh   <= i_dividend;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= rem2;
                r_sh  <= r_sh << 2;
                r_q   <= {r_q[SH_W-3:0], ge1, ge2};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

[rtl/encoder_speed_averager_top.sv]
// Top level of the encoder speed averager: sequencer, velocity ring and output register.
//
//  channel   dir  handshake          payload
//  i_item    in   valid/ready        position s32, elapsed u24
//  o_result  out  valid/ready        instant_speed s16, averaged_speed s16, saturated u1
//  i_cfg_*   in   write enable only  index u1, data u48 (max_speed, reverse)
//
// All four divisions of an item share one restoring divider that retires two
// quotient bits per cycle (velocity term, Q4.12 scale of the term, window mean,
// Q4.12 scale of the mean). The ring of velocity terms lives in one RAM, read
// when an item is taken and written once its term is known.
// Reset is synchronous and clears control state, the last position, the running
// sum and the per-entry valid bits of the ring; no clearing pass is needed.
// A finished result sits in the output register while the next item is taken;
// the sequencer only stalls if a second result completes before the first drains.
`default_nettype none

module encoder_speed_averager_top #(
    parameter int SAMPLE_WINDOW = 9
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    esa_in_if.sink                                    i_item,
    esa_out_if.source                                 o_result,
    input  wire logic                                 i_cfg_we,
    input  wire logic [esa_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [esa_pkg::CFG_W-1:0]            i_cfg_data
);
    localparam int HIST_DEPTH = SAMPLE_WINDOW - 1;
    localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int TW         = esa_pkg::TERM_W;
    localparam int DW         = esa_pkg::DIV_W;
    localparam int PW         = esa_pkg::POS_W;
    localparam int SW         = esa_pkg::SPD_W;
    // Running sum holds HIST_DEPTH signed terms exactly
    localparam int SUM_W      = TW + $clog2(HIST_DEPTH) + 1;
    // Mean dividend padded to a whole number of bit pairs
    localparam int MAG_W      = ((SUM_W + 1) / 2) * 2;
    // Term dividend: leading pad bit, |delta| (33 bits), 16 fraction bits
    localparam int TDIV_W     = 50;
    // Q4.12 scale: quotient below 2^17, run as 18 bits
    localparam int SC_W       = 18;
    localparam int SH_W       = (MAG_W > TDIV_W) ? MAG_W : TDIV_W;
    localparam int CNT_W      = $clog2(SH_W / 2 + 1);

    localparam logic [TW:0] TERM_MAX_MAG = {2'b00, {(TW-1){1'b1}}};
    localparam logic [TW:0] TERM_MIN_MAG = {2'b01, {(TW-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_TERM,
        S_SUM,
        S_SCI,
        S_MEAN_ST,
        S_MEAN,
        S_SCA_ST,
        S_SCA,
        S_HOLD
    } t_state;

    // Clip a Q4.12 magnitude to signed 16 bits; returns {clip, value}
    function automatic logic [SW:0] clamp_q412(input logic neg, input logic big,
                                                input logic [SC_W-1:0] m);
        logic [SW:0] res;
        if (neg) begin
            if (big || (m > SC_W'(32768))) begin
                res = {1'b1, 16'h8000};
            end else begin
                res = {1'b0, 16'(-m[SW-1:0])};
            end
        end else begin
            if (big || (m > SC_W'(32767))) begin
                res = {1'b1, 16'h7FFF};
            end else begin
                res = {1'b0, m[SW-1:0]};
            end
        end
        return res;
    endfunction

    t_state                r_state;
    logic [DW-1:0]         r_max_speed;
    logic                  r_reverse;
    logic signed [PW-1:0]  r_last;
    logic [IDX_W-1:0]      r_idx;
    logic [HIST_DEPTH-1:0] r_valid;
    logic signed [SUM_W-1:0] r_sum;
    logic                  r_dneg;
    logic [TW-1:0]         r_term;
    logic [TW-1:0]         r_term_mag;
    logic                  r_term_neg;
    logic [TW-1:0]         r_mean_mag;
    logic                  r_big;
    logic                  r_sc_neg;
    logic [SW-1:0]         r_inst;
    logic                  r_clip_i;
    logic [SW-1:0]         r_avg;
    logic                  r_clip_a;
    logic                  r_ovalid;
    logic [SW-1:0]         r_out_inst;
    logic [SW-1:0]         r_out_avg;
    logic                  r_out_sat;

    logic                  in_acc;
    logic                  out_free;
    logic signed [PW:0]    delta;
    logic [PW:0]           dmag;
    logic [esa_pkg::EL_W-1:0] el_eff;
    logic [DW-1:0]         div_eff;
    logic [TW-1:0]         ram_rdata;
    logic [TW-1:0]         old_term;
    logic signed [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0]      sum_mag;
    logic [TW:0]           tmag;
    logic [TW:0]           tmag_sat;
    logic [TW-1:0]         sc_mag;
    logic                  sc_big;
    logic [SW:0]           sc_res;

    logic                  div_start;
    logic [DW-1:0]         div_divisor;
    logic [DW-1:0]         div_rem_init;
    logic [SH_W-1:0]       div_dividend;
    logic [CNT_W-1:0]      div_pairs;
    logic                  div_done;
    logic [SH_W-1:0]       div_q;

    assign in_acc   = i_item.valid && i_item.ready;
    assign out_free = !r_ovalid || o_result.ready;

    // Velocity term operands: last - position, elapsed forced to at least one tick
    always_comb begin
        delta  = {r_last[PW-1], r_last} - {i_item.position[PW-1], i_item.position};
        dmag   = delta[PW] ? (PW+1)'(-delta) : (PW+1)'(delta);
        el_eff = (i_item.elapsed == '0) ? esa_pkg::EL_W'(1) : i_item.elapsed;
        div_eff = (r_max_speed == '0) ? DW'(1) : r_max_speed;
    end

    // Ring update: drop the oldest term, add the newest
    always_comb begin
        old_term = r_valid[r_idx] ? ram_rdata : '0;
        n_sum    = r_sum + SUM_W'($signed(r_term)) - SUM_W'($signed(old_term));
        sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    end

    // Saturate the term magnitude to the signed 48-bit range
    always_comb begin
        tmag = div_q[TW:0];
        if (r_dneg) begin
            tmag_sat = (tmag > TERM_MIN_MAG) ? TERM_MIN_MAG : tmag;
        end else begin
            tmag_sat = (tmag > TERM_MAX_MAG) ? TERM_MAX_MAG : tmag;
        end
    end

    // Q4.12 scale: a magnitude at or above 32 * max_speed clips outright
    always_comb begin
        sc_mag = (r_state == S_SUM) ? r_term_mag : r_mean_mag;
        sc_big = ({5'b0, sc_mag[TW-1:5]} >= div_eff);
        sc_res = clamp_q412(r_sc_neg, r_big, div_q[SC_W-1:0]);
    end

    // Divider operand selection
    always_comb begin
        div_start    = 1'b0;
        div_divisor  = div_eff;
        div_rem_init = '0;
        div_dividend = '0;
        div_pairs    = '0;
        unique case (r_state)
            S_IDLE: begin
                div_start    = in_acc;
                div_divisor  = DW'(el_eff);
                div_dividend = SH_W'({1'b0, dmag, 16'b0}) << (SH_W - TDIV_W);
                div_pairs    = CNT_W'(TDIV_W / 2);
            end
            S_SUM, S_SCA_ST: begin
                div_start    = 1'b1;
                div_rem_init = DW'(sc_mag[TW-1:6]);
                div_dividend = SH_W'({sc_mag[5:0], 12'b0}) << (SH_W - SC_W);
                div_pairs    = CNT_W'(SC_W / 2);
            end
            S_MEAN_ST: begin
                div_start    = 1'b1;
                div_divisor  = DW'(HIST_DEPTH);
                div_dividend = SH_W'(sum_mag) << (SH_W - MAG_W);
                div_pairs    = CNT_W'(MAG_W / 2);
            end
            S_TERM, S_SCI, S_MEAN, S_SCA, S_HOLD: begin
                div_start = 1'b0;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    esa_div #(
        .SH_W  (SH_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (div_divisor),
        .i_rem_init (div_rem_init),
        .i_dividend (div_dividend),
        .i_pairs    (div_pairs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Read the slot to overwrite as the item comes in; write it back once the term is known
    esa_ram #(
        .WIDTH (TW),
        .DEPTH (HIST_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_SUM),
        .i_waddr (r_idx),
        .i_wdata (r_term),
        .i_re    (in_acc),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= esa_pkg::MAX_SPEED_RST;
            r_reverse   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (esa_pkg::t_cfg_reg'(i_cfg_idx))
                esa_pkg::REG_MAX_SPEED: r_max_speed <= i_cfg_data;
                esa_pkg::REG_REVERSE:   r_reverse   <= i_cfg_data[0];
            endcase
        end
    end

    // Sequencer, ring state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_last   <= '0;
            r_idx    <= '0;
            r_valid  <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Drain the output register; in S_HOLD the reload below decides
            if (r_ovalid && o_result.ready && (r_state != S_HOLD)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_dneg  <= delta[PW];
                        r_last  <= i_item.position;
                        r_state <= S_TERM;
                    end
                end
                S_TERM: begin
                    if (div_done) begin
                        r_term_mag <= tmag_sat[TW-1:0];
                        r_term     <= r_dneg ? TW'(-tmag_sat[TW-1:0]) : tmag_sat[TW-1:0];
                        r_term_neg <= r_dneg;
                        r_state    <= S_SUM;
                    end
                end
                S_SUM: begin
                    // Ring write and instant scale start happen here
                    r_sum          <= n_sum;
                    r_valid[r_idx] <= 1'b1;
                    r_idx          <= (r_idx == IDX_W'(HIST_DEPTH - 1)) ? '0 : r_idx + 1'b1;
                    r_big          <= sc_big;
                    r_sc_neg       <= r_term_neg ^ r_reverse;
                    r_state        <= S_SCI;
                end
                S_SCI: begin
                    if (div_done) begin
                        r_inst   <= sc_res[SW-1:0];
                        r_clip_i <= sc_res[SW];
                        r_state  <= S_MEAN_ST;
                    end
                end
                S_MEAN_ST: begin
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_mean_mag <= div_q[TW-1:0];
                        r_state    <= S_SCA_ST;
                    end
                end
                S_SCA_ST: begin
                    r_big    <= sc_big;
                    r_sc_neg <= r_sum[SUM_W-1] ^ r_reverse;
                    r_state  <= S_SCA;
                end
                S_SCA: begin
                    if (div_done) begin
                        r_avg    <= sc_res[SW-1:0];
                        r_clip_a <= sc_res[SW];
                        r_state  <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    // Hold the result until the output register frees up
                    if (out_free) begin
                        r_ovalid   <= 1'b1;
                        r_out_inst <= r_inst;
                        r_out_avg  <= r_avg;
                        r_out_sat  <= r_clip_i | r_clip_a;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_ovalid;
    assign o_result.instant_speed  = r_out_inst;
    assign o_result.averaged_speed = r_out_avg;
    assign o_result.saturated      = r_out_sat;

endmodule

`default_nettype wire

[verif/encoder_speed_averager_top_test.sv]
// Self-checking bench for the encoder speed averager: random bursts, stalls and register settings.
`default_nettype none

module encoder_speed_averager_top_test;

    // Ring geometry follows the window that the block is built with
    localparam int WINDOW     = 9;
    localparam int RING_DEPTH = WINDOW - 1;

    // Velocity terms are clipped to signed 48 bits before they enter the ring
    localparam longint TERM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint TERM_MIN = -TERM_MAX - 1;

    // Settling time once the last result is in, beyond the time an item takes
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic signed [esa_pkg::POS_W-1:0] position;
        logic        [esa_pkg::EL_W-1:0]  elapsed;
    } t_sample;

    typedef struct packed {
        logic signed [esa_pkg::SPD_W-1:0] instant_speed;
        logic signed [esa_pkg::SPD_W-1:0] averaged_speed;
        logic                             saturated;
    } t_speeds;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [esa_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [esa_pkg::CFG_W-1:0]     cfg_data;

    esa_in_if  in_bus ();
    esa_out_if out_bus ();

    encoder_speed_averager_top #(
        .SAMPLE_WINDOW (WINDOW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_bus),
        .o_result   (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Samples waiting for the driver, and speeds waiting for the monitor
    t_sample pending_samples[$];
    t_speeds expected_speeds[$];

    // Mirror of the block: registers, last position, velocity ring and its sum
    logic [esa_pkg::CFG_W-1:0]          full_scale;
    logic                               reverse_dir;
    logic signed [esa_pkg::POS_W-1:0]   prev_position;
    logic signed [esa_pkg::TERM_W-1:0]  velocity_ring [RING_DEPTH];
    longint                             ring_sum;
    int                                 ring_slot;

    // Position of the last sample queued, so that random moves stay plausible
    logic signed [esa_pkg::POS_W-1:0]   gen_pos;

    int mismatches = 0;

    // Clock: period of 10
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: generous bound on the slowest legal run
    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Scale a velocity by 4096 / divisor on its magnitude, flip the sign if asked,
    // and clip to signed 16 bits.
    function automatic logic signed [esa_pkg::SPD_W-1:0] to_q412(
                                                        input longint v,
                                                        input longint unsigned divisor,
                                                        input bit flip,
                                                        output bit clipped);
        bit                neg;
        longint unsigned   mag;
        longint unsigned   quo;
        longint unsigned   rem;
        longint unsigned   m;
        logic [63:0]       neg_m;
        clipped = 1'b0;
        neg = v < 0;
        mag = neg ? -v : v;
        quo = mag / divisor;
        rem = mag % divisor;
        // Anything past eight full scales clips whatever the fraction is
        m = (quo > 64'd8) ? 64'd65536 : quo * 64'd4096 + (rem * 64'd4096) / divisor;
        neg = neg ^ flip;
        if (neg) begin
            if (m > 64'd32768) begin
                m = 64'd32768;
                clipped = 1'b1;
            end
            neg_m = 64'd0 - m;
            return neg_m[esa_pkg::SPD_W-1:0];
        end
        if (m > 64'd32767) begin
            m = 64'd32767;
            clipped = 1'b1;
        end
        return m[esa_pkg::SPD_W-1:0];
    endfunction

    // Advance the mirror by one accepted sample and queue the speeds it must yield
    task automatic predict_speeds(input logic signed [esa_pkg::POS_W-1:0] pos,
                                  input logic [esa_pkg::EL_W-1:0] el);
        longint            delta;
        longint unsigned   dmag;
        longint unsigned   tmag;
        longint unsigned   ticks;
        longint unsigned   divisor;
        longint            term;
        longint            mean;
        bit                clip_inst;
        bit                clip_avg;
        t_speeds           res;
        // A zero tick count counts as one tick, a zero full scale as one
        ticks   = (el == '0) ? 64'd1 : 64'(el);
        divisor = (full_scale == '0) ? 64'd1 : 64'(full_scale);

        delta = longint'(prev_position) - longint'(pos);
        dmag  = (delta < 0) ? -delta : delta;
        tmag  = (dmag << 16) / ticks;
        // Clip the term to signed 48 bits; this does not raise the flag
        if (delta < 0)
            term = (tmag > TERM_MAX + 1) ? TERM_MIN : -longint'(tmag);
        else
            term = (tmag > TERM_MAX) ? TERM_MAX : longint'(tmag);
        prev_position = pos;

        // Replace the oldest ring entry and keep the exact sum
        ring_sum = ring_sum + term - longint'(velocity_ring[ring_slot]);
        velocity_ring[ring_slot] = term[esa_pkg::TERM_W-1:0];
        ring_slot = (ring_slot + 1) % RING_DEPTH;
        mean = ring_sum / RING_DEPTH;

        res.instant_speed  = to_q412(term, divisor, reverse_dir, clip_inst);
        res.averaged_speed = to_q412(mean, divisor, reverse_dir, clip_avg);
        res.saturated      = clip_inst | clip_avg;
        expected_speeds.push_back(res);
    endtask

    // Write one register while the block is idle, and mirror it
    task automatic write_reg(input esa_pkg::t_cfg_reg idx,
                             input logic [esa_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            esa_pkg::REG_MAX_SPEED: full_scale  = value;
            esa_pkg::REG_REVERSE:   reverse_dir = value[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic queue_sample(input logic signed [esa_pkg::POS_W-1:0] pos,
                                input logic [esa_pkg::EL_W-1:0] el);
        t_sample s;
        s.position = pos;
        s.elapsed  = el;
        pending_samples.push_back(s);
        gen_pos = pos;
    endtask

    // Hold until every queued sample is in and every result has drained, then settle
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_samples.size() != 0 || in_bus.valid || expected_speeds.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued samples in bursts of random length, with random
    // gaps in between; some bursts follow on with no gap at all.
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        t_sample nxt;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            // Mirror starts from the reset state
            prev_position = '0;
            for (int i = 0; i < RING_DEPTH; i++)
                velocity_ring[i] = '0;
            ring_sum  = 0;
            ring_slot = 0;
        end else begin
            // Predict on the edge that moves the item
            if (in_bus.valid && in_bus.ready)
                predict_speeds(in_bus.position, in_bus.elapsed);
            // Only touch the channel once the held item has gone
            if (!in_bus.valid || in_bus.ready) begin
                if (gap_left > 0 || pending_samples.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    in_bus.valid <= 1'b0;
                end else begin
                    nxt = pending_samples.pop_front();
                    in_bus.valid    <= 1'b1;
                    in_bus.position <= nxt.position;
                    in_bus.elapsed  <= nxt.elapsed;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 11);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result against the oldest prediction, and drive
    // ready on a stall pattern of its own. The pattern changes every
    // stretch: always ready, coin toss, mostly stalled, or held off.
    // ------------------------------------------------------------------
    int stall_mode;
    int stretch_left;

    always @(posedge i_clk) begin
        t_speeds want;
        bit      rdy;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            stall_mode   = 0;
            stretch_left = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_speeds.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: inst %0d avg %0d sat %0b",
                                 out_bus.instant_speed, out_bus.averaged_speed,
                                 out_bus.saturated);
                    mismatches++;
                end else begin
                    want = expected_speeds.pop_front();
                    if (out_bus.instant_speed  !== want.instant_speed  ||
                        out_bus.averaged_speed !== want.averaged_speed ||
                        out_bus.saturated      !== want.saturated) begin
                        if (mismatches < 10)
                            $display({"speed mismatch: want inst %0d avg %0d sat %0b, ",
                                      "got inst %0d avg %0d sat %0b"},
                                     want.instant_speed, want.averaged_speed, want.saturated,
                                     out_bus.instant_speed, out_bus.averaged_speed,
                                     out_bus.saturated);
                        mismatches++;
                    end
                end
            end

            if (stretch_left == 0) begin
                stall_mode   = $urandom_range(0, 3);
                stretch_left = (stall_mode == 3) ? $urandom_range(10, 150)
                                                 : $urandom_range(20, 300);
            end else begin
                stretch_left--;
            end
            case (stall_mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = ($urandom_range(0, 7) == 0);
                default: rdy = 1'b0;
            endcase
            out_bus.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed samples over the register extremes, then
    // random phases, each under a fresh register setting.
    // ------------------------------------------------------------------
    initial begin
        logic [63:0]                      wide;
        logic [esa_pkg::CFG_W-1:0]        scale;
        logic signed [esa_pkg::POS_W-1:0] pos;
        logic [esa_pkg::EL_W-1:0]         el;
        int                               k;
        int                               m;
        int                               mag;

        // Drive the reset and register inputs to a known value from the start
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= esa_pkg::REG_MAX_SPEED;
        cfg_data        <= '0;

        // Register mirror starts from the reset state
        full_scale    = esa_pkg::MAX_SPEED_RST;
        reverse_dir   = 1'b0;
        gen_pos       = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: stationary, full-range moves, both term clips,
        // zero elapsed, rounding toward zero on either side
        queue_sample(32'sd0,           24'd1);
        queue_sample(32'sh7FFF_FFFF,   24'd1);
        queue_sample(32'sh8000_0000,   24'd1);
        queue_sample(32'sh7FFF_FFFF,   24'd1);
        queue_sample(32'sh7FFF_FFFF,   24'hFF_FFFF);
        queue_sample(32'sh7FFF_FFFE,   24'hFF_FFFF);
        queue_sample(32'sh7FFF_FF00,   24'd0);
        queue_sample(32'sh7FFF_FF01,   24'd3);
        queue_sample(32'sh7FFF_FF00,   24'd3);
        queue_sample(32'sh7FFF_FF00,   24'd1);
        wait_idle();

        // Smallest full scale, reversed: nearly every move clips
        write_reg(esa_pkg::REG_MAX_SPEED, 48'd1);
        write_reg(esa_pkg::REG_REVERSE,   48'd1);
        queue_sample(32'sh7FFF_FF01,   24'd1);
        queue_sample(32'sh7FFF_FF01,   24'd1);
        queue_sample(32'sh7FFF_FF00,   24'd5);
        wait_idle();

        // Largest full scale, forward: clipped terms stay in range
        write_reg(esa_pkg::REG_MAX_SPEED, 48'hFFFF_FFFF_FFFF);
        write_reg(esa_pkg::REG_REVERSE,   48'd0);
        queue_sample(32'sh8000_0000,   24'd1);
        queue_sample(32'sh7FFF_FFFF,   24'd1);
        queue_sample(32'sd0,           24'hFF_FFFF);
        wait_idle();

        // Zero full scale counts as one
        write_reg(esa_pkg::REG_MAX_SPEED, 48'd0);
        write_reg(esa_pkg::REG_REVERSE,   48'd1);
        queue_sample(32'sd5,           24'd2);
        queue_sample(32'sd0,           24'd1);
        wait_idle();

        // Random phases
        for (int phase = 0; phase < 8; phase++) begin
            wide = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0:       scale = 48'd1;
                1:       scale = 48'hFFFF_FFFF_FFFF;
                2:       scale = wide[esa_pkg::CFG_W-1:0];
                3:       scale = esa_pkg::MAX_SPEED_RST;
                default: begin
                    // Pick a scale near the typical term so outputs land in range
                    k = $urandom_range(4, 40);
                    scale = (48'd1 << k) | (wide[esa_pkg::CFG_W-1:0] & ((48'd1 << k) - 48'd1));
                end
            endcase
            write_reg(esa_pkg::REG_MAX_SPEED, scale);
            write_reg(esa_pkg::REG_REVERSE,   {47'd0, 1'($urandom_range(0, 1))});

            for (int n = 0; n < 210; n++) begin
                case ($urandom_range(0, 19))
                    // Full-width noise on both fields
                    0, 1, 2: begin
                        pos = $urandom;
                        el  = esa_pkg::EL_W'($urandom_range(1, 24'hFF_FFFF));
                    end
                    // Tick count at either end
                    3, 4: begin
                        mag = $urandom_range(0, 1 << $urandom_range(0, 24));
                        pos = $urandom_range(0, 1) ? gen_pos + mag : gen_pos - mag;
                        el  = $urandom_range(0, 1) ? 24'd1 : 24'hFF_FFFF;
                    end
                    // Jumps across the position extremes
                    5, 6, 7: begin
                        case ($urandom_range(0, 4))
                            0:       pos = 32'sh7FFF_FFFF;
                            1:       pos = 32'sh8000_0000;
                            2:       pos = 32'sd0;
                            3:       pos = -32'sd1;
                            default: pos = 32'sd1;
                        endcase
                        el = $urandom_range(0, 1) ? 24'd1
                                                  : esa_pkg::EL_W'($urandom_range(1, 24'hFF_FFFF));
                    end
                    // Plausible motion: small moves over spans of varied length
                    default: begin
                        k   = $urandom_range(0, 24);
                        mag = $urandom_range(0, 1 << k);
                        pos = $urandom_range(0, 1) ? gen_pos + mag : gen_pos - mag;
                        m   = $urandom_range(0, 23);
                        el  = esa_pkg::EL_W'($urandom_range(1, (1 << (m + 1)) - 1));
                    end
                endcase
                queue_sample(pos, el);
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[encoder_speed_averager_top.f]
rtl/esa_pkg.sv
rtl/esa_in_if.sv
rtl/esa_out_if.sv
rtl/esa_ram.sv
rtl/esa_div.sv
rtl/encoder_speed_averager_top.sv
verif/encoder_speed_averager_top_test.sv
